@@ hdl/tbps_pkg.sv @@
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared types and constants for the token bucket packet slot scheduler.
// ----------------------------------------------------------------------------
package tbps_pkg;

  localparam int unsigned MAX_STREAMS_DEF = 4;
  localparam int unsigned NUM_RATES       = 4;

  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned RATE_W    = 23;
  localparam int unsigned FRAME_W   = 13;
  localparam int unsigned PAYLOAD_W = 10;
  localparam int unsigned SLOT_W    = 11;
  localparam int unsigned NEED_W    = 20;
  localparam int unsigned BUCKET_W  = 32;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned ID_W      = 2;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 23;

  localparam logic [SLOT_W-1:0] HEADER_BYTES = 11'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT   = 3'd0,
    CFG_RATE_0  = 3'd1,
    CFG_RATE_1  = 3'd2,
    CFG_RATE_2  = 3'd3,
    CFG_RATE_3  = 3'd4,
    CFG_FRAME   = 3'd5,
    CFG_PAYLOAD = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_SLOT  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_DUMMY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREDIT,
    S_DIV,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } bucket_op_e;

  typedef struct packed {
    logic            en;
    bucket_op_e      op;
    logic [ID_W-1:0] idx;
  } bucket_cmd_t;

endpackage

@@ hdl/tbps_div.sv @@
// ----------------------------------------------------------------------------
// tbps_div
// Restoring divider, one quotient bit per cycle: frame length by slot size.
// ----------------------------------------------------------------------------
module tbps_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tbps_pkg::FRAME_W-1:0]     dividend_i,
  input  logic [tbps_pkg::SLOT_W-1:0]      divisor_i,
  output logic                             busy_o,
  output logic [tbps_pkg::FRAME_W-1:0]     quot_o,
  output logic [tbps_pkg::FRAME_W-1:0]     rem_o
);

  localparam int unsigned CntW = $clog2(tbps_pkg::FRAME_W);

  logic                         busy_q;
  logic [CntW-1:0]              cnt_q;
  logic [tbps_pkg::FRAME_W-1:0] quo_q;
  logic [tbps_pkg::FRAME_W-1:0] rem_q;
  logic [tbps_pkg::SLOT_W-1:0]  dsor_q;

  logic [tbps_pkg::FRAME_W:0]   trial;
  logic [tbps_pkg::FRAME_W:0]   diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[tbps_pkg::FRAME_W-1]};
  assign diff  = trial - (tbps_pkg::FRAME_W+1)'(dsor_q);
  assign fits  = trial >= (tbps_pkg::FRAME_W+1)'(dsor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsor_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(tbps_pkg::FRAME_W - 1);
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dsor_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits always suffice
      rem_q <= fits ? diff[tbps_pkg::FRAME_W-1:0] : trial[tbps_pkg::FRAME_W-1:0];
      quo_q <= {quo_q[tbps_pkg::FRAME_W-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/tbps_bucket.sv @@
// ----------------------------------------------------------------------------
// tbps_bucket
// Credit bucket store with one shared add/subtract unit: saturating credit
// add on frame start, compare and debit on slot scan.
// ----------------------------------------------------------------------------
module tbps_bucket #(
  parameter int unsigned MaxStreams = tbps_pkg::MAX_STREAMS_DEF
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  tbps_pkg::bucket_cmd_t                                    cmd_i,
  input  logic [tbps_pkg::NUM_RATES-1:0][tbps_pkg::RATE_W-1:0]     rate_i,
  input  logic [tbps_pkg::NEED_W-1:0]                              need_i,
  output logic                                                     ge_o
);

  localparam int unsigned IdxW = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;
  localparam int unsigned BW   = tbps_pkg::BUCKET_W;

  logic [BW-1:0] bucket_q [MaxStreams];

  logic          is_sub;
  logic [BW-1:0] cur;
  logic [BW-1:0] operand;
  logic [BW:0]   res;
  logic          carry;

  assign is_sub  = (cmd_i.op == tbps_pkg::OP_SUB);
  assign cur     = bucket_q[cmd_i.idx[IdxW-1:0]];
  assign operand = is_sub ? BW'(need_i) : BW'(rate_i[cmd_i.idx]);
  // one adder: subtraction by inverted operand and carry in
  assign res     = {1'b0, cur} + {1'b0, (is_sub ? ~operand : operand)} + (BW+1)'(is_sub);
  assign carry   = res[BW];
  assign ge_o    = carry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxStreams; i++) begin
        bucket_q[i] <= '0;
      end
    end else if (cmd_i.en) begin
      if (!is_sub) begin
        bucket_q[cmd_i.idx[IdxW-1:0]] <= carry ? '1 : res[BW-1:0];
      end else if (carry) begin
        bucket_q[cmd_i.idx[IdxW-1:0]] <= res[BW-1:0];
      end
    end
  end

endmodule

@@ hdl/token_bucket_packet_slot_scheduler.sv @@
// ----------------------------------------------------------------------------
// token_bucket_packet_slot_scheduler
// Fills the packet slots of a frame from up to four streams by credit buckets.
// ----------------------------------------------------------------------------
// One transaction at a time; the input is held off until the result has moved
// into the output register. A frame start runs the bit-serial divider that
// splits the frame into slots (one quotient bit per cycle); the per-stream
// credit adds run beside it on the shared bucket adder. A slot offer that
// scans examines the stream buckets (1 to MAX_STREAMS) in turn, one per cycle
// on that same adder, until one is granted; an offer with no slot left or in
// an exhausted frame returns its result without a scan. The next transaction
// is taken while a result still waits in the output register; a second
// finished result waits for the output to drain.
module token_bucket_packet_slot_scheduler #(
  parameter int unsigned MAX_STREAMS = tbps_pkg::MAX_STREAMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbps_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [tbps_pkg::MASK_W-1:0]       ready_mask_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        kind_o,
  output logic [tbps_pkg::ID_W-1:0]         stream_id_o,
  output logic [tbps_pkg::FRAME_W-1:0]      slots_left_o,
  output logic [tbps_pkg::FRAME_W-1:0]      pad_bytes_o
);

  localparam int unsigned CW = tbps_pkg::COUNT_W;
  localparam int unsigned FW = tbps_pkg::FRAME_W;
  localparam int unsigned IW = tbps_pkg::ID_W;

  tbps_pkg::state_e state_q, state_d;

  // configuration registers
  logic [CW-1:0]                                          count_q;
  logic [tbps_pkg::NUM_RATES-1:0][tbps_pkg::RATE_W-1:0]   rate_q;
  logic [FW-1:0]                                          frame_len_q;
  logic [tbps_pkg::PAYLOAD_W-1:0]                         payload_q;

  // scheduler state
  logic [tbps_pkg::PTR_W-1:0]  ptr_q;
  logic [FW-1:0]               slots_q;
  logic                        exh_q;
  logic [tbps_pkg::MASK_W-1:0] ready_q;
  logic [IW-1:0]               cnt_q;
  logic [IW-1:0]               pcur_q;

  // pending result
  tbps_pkg::kind_e res_kind_q;
  logic [IW-1:0]   res_id_q;
  logic [FW-1:0]   res_left_q;
  logic [FW-1:0]   res_pad_q;

  // output register
  logic            out_valid_q;
  tbps_pkg::kind_e out_kind_q;
  logic [IW-1:0]   out_id_q;
  logic [FW-1:0]   out_left_q;
  logic [FW-1:0]   out_pad_q;

  logic [CW-1:0]                 n_use;
  logic [tbps_pkg::SLOT_W-1:0]   slot;
  logic [tbps_pkg::NEED_W-1:0]   need;
  logic [IW-1:0]                 ptr_wrap;
  logic [CW-1:0]                 ptr_inc;
  logic [IW-1:0]                 frame_ptr;
  logic [CW-1:0]                 pcur_inc;
  logic [IW-1:0]                 pnext;
  logic [IW-1:0]                 dummy_id;
  logic                          last_step;
  logic                          grant;
  logic                          out_free;
  logic                          in_accept;
  logic                          div_start;
  logic                          div_busy;
  logic [FW-1:0]                 div_quot;
  logic [FW-1:0]                 div_rem;
  logic                          bucket_ge;
  tbps_pkg::bucket_cmd_t         bucket_cmd;

  // a count of zero acts as one, above the stream limit as the limit
  always_comb begin
    if (count_q == '0) begin
      n_use = CW'(1);
    end else if (count_q > CW'(MAX_STREAMS)) begin
      n_use = CW'(MAX_STREAMS);
    end else begin
      n_use = count_q;
    end
  end

  assign slot = tbps_pkg::SLOT_W'(payload_q) + tbps_pkg::HEADER_BYTES;
  // 800 credits per slot byte: 512 + 256 + 32
  assign need = (tbps_pkg::NEED_W'(slot) << 9) + (tbps_pkg::NEED_W'(slot) << 8)
              + (tbps_pkg::NEED_W'(slot) << 5);

  assign ptr_wrap  = (ptr_q >= n_use) ? '0 : ptr_q[IW-1:0];
  assign ptr_inc   = CW'(ptr_wrap) + CW'(1);
  assign frame_ptr = (ptr_inc >= n_use) ? '0 : ptr_inc[IW-1:0];
  assign pcur_inc  = CW'(pcur_q) + CW'(1);
  assign pnext     = (pcur_inc >= n_use) ? '0 : pcur_inc[IW-1:0];
  assign dummy_id  = (n_use >= CW'(3)) ? IW'(3) : n_use[IW-1:0];
  assign last_step = (CW'(cnt_q) == (n_use - CW'(1)));
  assign grant     = ready_q[pcur_q] & bucket_ge;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && (state_q == tbps_pkg::S_IDLE);
  assign div_start = in_accept && (action_i == tbps_pkg::ACT_FRAME);

  tbps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (frame_len_q),
    .divisor_i  (slot),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  tbps_bucket #(
    .MaxStreams (MAX_STREAMS)
  ) u_bucket (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (bucket_cmd),
    .rate_i (rate_q),
    .need_i (need),
    .ge_o   (bucket_ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    bucket_cmd.en  = 1'b0;
    bucket_cmd.op  = tbps_pkg::OP_ADD;
    bucket_cmd.idx = cnt_q;
    case (state_q)
      tbps_pkg::S_IDLE: begin
        if (in_accept) begin
          if (action_i == tbps_pkg::ACT_FRAME) begin
            state_d = tbps_pkg::S_CREDIT;
          end else if (slots_q == '0 || exh_q) begin
            state_d = tbps_pkg::S_DONE;
          end else begin
            state_d = tbps_pkg::S_SCAN;
          end
        end
      end
      tbps_pkg::S_CREDIT: begin
        bucket_cmd.en = 1'b1;
        if (last_step) begin
          state_d = tbps_pkg::S_DIV;
        end
      end
      tbps_pkg::S_DIV: begin
        if (!div_busy) begin
          state_d = tbps_pkg::S_DONE;
        end
      end
      tbps_pkg::S_SCAN: begin
        // debit only lands when the stream is ready and the bucket covers it
        bucket_cmd.en  = ready_q[pcur_q];
        bucket_cmd.op  = tbps_pkg::OP_SUB;
        bucket_cmd.idx = pcur_q;
        if (grant || last_step) begin
          state_d = tbps_pkg::S_DONE;
        end
      end
      tbps_pkg::S_DONE: begin
        if (out_free) begin
          state_d = tbps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tbps_pkg::S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      rate_q      <= '0;
      frame_len_q <= '0;
      payload_q   <= tbps_pkg::PAYLOAD_W'(1);
    end else if (cfg_valid_i) begin
      case (tbps_pkg::cfg_reg_e'(cfg_index_i))
        tbps_pkg::CFG_COUNT:   count_q     <= cfg_data_i[CW-1:0];
        tbps_pkg::CFG_RATE_0:  rate_q[0]   <= cfg_data_i;
        tbps_pkg::CFG_RATE_1:  rate_q[1]   <= cfg_data_i;
        tbps_pkg::CFG_RATE_2:  rate_q[2]   <= cfg_data_i;
        tbps_pkg::CFG_RATE_3:  rate_q[3]   <= cfg_data_i;
        tbps_pkg::CFG_FRAME:   frame_len_q <= cfg_data_i[FW-1:0];
        tbps_pkg::CFG_PAYLOAD: payload_q   <= cfg_data_i[tbps_pkg::PAYLOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // scheduler datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      slots_q    <= '0;
      exh_q      <= 1'b0;
      ready_q    <= '0;
      cnt_q      <= '0;
      pcur_q     <= '0;
      res_kind_q <= tbps_pkg::KIND_FRAME;
      res_id_q   <= '0;
      res_left_q <= '0;
      res_pad_q  <= '0;
    end else begin
      case (state_q)
        tbps_pkg::S_IDLE: begin
          if (in_accept) begin
            ready_q <= ready_mask_i;
            cnt_q   <= '0;
            pcur_q  <= ptr_wrap;
            if (action_i == tbps_pkg::ACT_SLOT) begin
              if (slots_q == '0) begin
                res_kind_q <= tbps_pkg::KIND_NONE;
                res_id_q   <= '0;
                res_left_q <= '0;
                res_pad_q  <= '0;
              end else if (exh_q) begin
                res_kind_q <= tbps_pkg::KIND_DUMMY;
                res_id_q   <= dummy_id;
                res_left_q <= slots_q - FW'(1);
                res_pad_q  <= '0;
                slots_q    <= slots_q - FW'(1);
              end
            end
          end
        end
        tbps_pkg::S_CREDIT: begin
          cnt_q <= cnt_q + IW'(1);
        end
        tbps_pkg::S_DIV: begin
          if (!div_busy) begin
            slots_q    <= div_quot;
            exh_q      <= 1'b0;
            ptr_q      <= tbps_pkg::PTR_W'(frame_ptr);
            res_kind_q <= tbps_pkg::KIND_FRAME;
            res_id_q   <= '0;
            res_left_q <= div_quot;
            res_pad_q  <= div_rem;
          end
        end
        tbps_pkg::S_SCAN: begin
          if (grant) begin
            // pointer may land on the stream count; it wraps before next use
            ptr_q      <= pcur_inc;
            res_kind_q <= tbps_pkg::KIND_GRANT;
            res_id_q   <= pcur_q;
            res_left_q <= slots_q - FW'(1);
            res_pad_q  <= '0;
            slots_q    <= slots_q - FW'(1);
          end else if (last_step) begin
            exh_q      <= 1'b1;
            res_kind_q <= tbps_pkg::KIND_DUMMY;
            res_id_q   <= dummy_id;
            res_left_q <= slots_q - FW'(1);
            res_pad_q  <= '0;
            slots_q    <= slots_q - FW'(1);
          end else begin
            pcur_q <= pnext;
            cnt_q  <= cnt_q + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= tbps_pkg::KIND_FRAME;
      out_id_q    <= '0;
      out_left_q  <= '0;
      out_pad_q   <= '0;
    end else if (state_q == tbps_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
      out_kind_q  <= res_kind_q;
      out_id_q    <= res_id_q;
      out_left_q  <= res_left_q;
      out_pad_q   <= res_pad_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != tbps_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign stream_id_o  = out_id_q;
  assign slots_left_o = out_left_q;
  assign pad_bytes_o  = out_pad_q;

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("scheduler took a transaction without going busy");

  a_scan_has_slot : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == tbps_pkg::S_SCAN |-> slots_q != '0 && !exh_q
  ) else $error("scan running with no slot left or in an exhausted frame");

  a_no_slot_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tbps_pkg::KIND_NONE |-> slots_left_o == '0 && stream_id_o == '0
  ) else $error("no-slot result carries a slot count or an id");

  a_grant_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tbps_pkg::KIND_GRANT |-> CW'(stream_id_o) < CW'(MAX_STREAMS)
  ) else $error("grant to a stream beyond the supported count");

endmodule
